@@ rtl/rstwa_pkg.sv @@
// Package: shared types and constants for the recent source table with aging.
`timescale 1ns / 1ps

package rstwa_pkg;

    // Operation codes of an input item
    localparam logic OP_EVENT = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // Configuration register indexes
    localparam logic CFG_TIMEOUT   = 1'b0;
    localparam logic CFG_THRESHOLD = 1'b1;

    // Configuration reset values
    localparam logic [15:0] TIMEOUT_RESET   = 16'd30;
    localparam logic [1:0]  THRESHOLD_RESET = 2'd3;

    // Slot code reported for a tick
    localparam logic [1:0] SLOT_NONE = 2'd3;

    // Input item
    typedef struct packed {
        logic        op;
        logic [15:0] src_addr;
        logic [31:0] now_sec;
    } t_in;

    // Result item
    typedef struct packed {
        logic       alarm_on;
        logic [1:0] active_count;
        logic [1:0] slot_used;
        logic [2:0] expired_mask;
    } t_out;

endpackage

@@ rtl/recent_source_table_with_aging.sv @@
// Top level: recent source table with aging, input and result registers.
// An item goes into the input register and moves on to the result register
//   when that register is free or drained. Throughput: one item per cycle while
//   the output is not stalled; the table update is a single compare pass over
//   all entries between the input register and the result register.
// Reset (synchronous, active low): all entries empty, alarm off,
//   timeout 30 s, alarm threshold 3; no clearing pass is needed.
`timescale 1ns / 1ps

module recent_source_table_with_aging import rstwa_pkg::*; #(
    parameter int ENTRIES = 3
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in         i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out        o_out_data
);

    logic [15:0]        r_timeout;
    logic [1:0]         r_threshold;
    logic               r_in_valid;
    t_in                r_in;
    logic               r_out_valid;
    t_out               r_out;
    logic [15:0]        r_addr  [ENTRIES];
    logic [31:0]        r_stamp [ENTRIES];
    logic [ENTRIES-1:0] r_valid;
    logic               r_alarm;

    logic [15:0]        n_addr  [ENTRIES];
    logic [31:0]        n_stamp [ENTRIES];
    logic [ENTRIES-1:0] n_valid;
    logic               n_alarm;
    t_out               n_out;
    logic               advance;

    // Item moves to the result register when that register is free or drained
    assign advance     = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !advance;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout   <= TIMEOUT_RESET;
            r_threshold <= THRESHOLD_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TIMEOUT:   r_timeout   <= i_cfg_data;
                CFG_THRESHOLD: r_threshold <= i_cfg_data[1:0];
                default:       r_timeout   <= r_timeout;
            endcase
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in_data;
        end
    end

    // Table update logic
    rstwa_calc #(
        .ENTRIES(ENTRIES)
    ) u_calc (
        .i_item      (r_in),
        .i_timeout   (r_timeout),
        .i_threshold (r_threshold),
        .i_addr      (r_addr),
        .i_stamp     (r_stamp),
        .i_valid     (r_valid),
        .i_alarm     (r_alarm),
        .o_addr      (n_addr),
        .o_stamp     (n_stamp),
        .o_valid     (n_valid),
        .o_alarm     (n_alarm),
        .o_result    (n_out)
    );

    // Table state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_alarm <= 1'b0;
        end else if (advance) begin
            r_valid <= n_valid;
            r_alarm <= n_alarm;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_addr  <= n_addr;
            r_stamp <= n_stamp;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

endmodule

@@ rtl/rstwa_calc.sv @@
// Combinational update of the table for one event or tick.
`timescale 1ns / 1ps

module rstwa_calc import rstwa_pkg::*; #(
    parameter int ENTRIES = 3
) (
    input  t_in         i_item,
    input  logic [15:0] i_timeout,
    input  logic [1:0]  i_threshold,
    input  logic [15:0] i_addr  [ENTRIES],
    input  logic [31:0] i_stamp [ENTRIES],
    input  logic [ENTRIES-1:0] i_valid,
    input  logic        i_alarm,
    output logic [15:0] o_addr  [ENTRIES],
    output logic [31:0] o_stamp [ENTRIES],
    output logic [ENTRIES-1:0] o_valid,
    output logic        o_alarm,
    output t_out        o_result
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int CMP_W = (CNT_W > 2) ? CNT_W : 2;
    localparam int MW    = (ENTRIES < 3) ? ENTRIES : 3;

    logic               hit_found;
    logic [IDX_W-1:0]   hit_idx;
    logic               empty_found;
    logic [IDX_W-1:0]   empty_idx;
    logic [IDX_W-1:0]   old_idx;
    logic [31:0]        old_age;
    logic [31:0]        age     [ENTRIES];
    logic [IDX_W-1:0]   slot;
    logic [ENTRIES-1:0] expired;
    logic [CNT_W-1:0]   count;

    // Age of every entry, modulo 2^32
    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            age[i] = i_item.now_sec - i_stamp[i];
        end
    end

    // Slot choice: matching address, then first empty, then oldest
    always_comb begin
        hit_found   = 1'b0;
        hit_idx     = '0;
        empty_found = 1'b0;
        empty_idx   = '0;
        old_idx     = '0;
        old_age     = age[0];
        for (int i = 0; i < ENTRIES; i++) begin
            if (!hit_found && i_valid[i] && (i_addr[i] == i_item.src_addr)) begin
                hit_found = 1'b1;
                hit_idx   = IDX_W'(i);
            end
            if (!empty_found && !i_valid[i]) begin
                empty_found = 1'b1;
                empty_idx   = IDX_W'(i);
            end
        end
        for (int i = 1; i < ENTRIES; i++) begin
            if (age[i] > old_age) begin
                old_age = age[i];
                old_idx = IDX_W'(i);
            end
        end
        if (hit_found) begin
            slot = hit_idx;
        end else if (empty_found) begin
            slot = empty_idx;
        end else begin
            slot = old_idx;
        end
    end

    // Entries freed by a tick
    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            expired[i] = (i_item.op == OP_TICK) && i_valid[i]
                         && (age[i] >= {16'd0, i_timeout});
        end
    end

    // Next table contents
    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            o_addr[i]  = i_addr[i];
            o_stamp[i] = i_stamp[i];
            o_valid[i] = i_valid[i] && !expired[i];
            if ((i_item.op == OP_EVENT) && (slot == IDX_W'(i))) begin
                o_addr[i]  = i_item.src_addr;
                o_stamp[i] = i_item.now_sec;
                o_valid[i] = 1'b1;
            end
        end
    end

    // Occupancy and alarm
    always_comb begin
        count = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            count = count + CNT_W'(o_valid[i]);
        end
        o_alarm = i_alarm;
        if (i_item.op == OP_EVENT) begin
            if (CMP_W'(count) >= CMP_W'(i_threshold)) begin
                o_alarm = 1'b1;
            end
        end else if (|expired) begin
            o_alarm = 1'b0;
        end
    end

    // Result fields
    always_comb begin
        o_result.alarm_on     = o_alarm;
        o_result.active_count = 2'(count);
        o_result.slot_used    = (i_item.op == OP_TICK) ? SLOT_NONE : 2'(slot);
        o_result.expired_mask = 3'(expired[MW-1:0]);
    end

endmodule
